// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/mwr_pkg.sv -----
// Types, codes and the CRC-16 byte step of the Modbus wind reading block
`timescale 1ns / 1ps
`default_nettype none

package mwr_pkg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] wind_tenths;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_DONE    = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [15:0] value;
    } t_cmd;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic REG_SLAVE   = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [7:0]  SLAVE_RESET   = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ  = 8'h03;
    localparam logic [7:0] BYTE_COUNT = 8'h02;
    localparam logic [7:0] REG_HI     = 8'h00;
    localparam logic [7:0] REG_LO     = 8'h00;
    localparam logic [7:0] CNT_HI     = 8'h00;
    localparam logic [7:0] CNT_LO     = 8'h01;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/mwr_cmd_fifo.sv -----
// Command queue between the frame matcher and the result sequencer
`timescale 1ns / 1ps
`default_nettype none

module mwr_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  mwr_pkg::t_cmd     i_cmd,
    output logic              o_full,
    input  wire               i_pop,
    output mwr_pkg::t_cmd     o_cmd,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mwr_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/mwr_front.sv -----
// Front end: accepts transactions, runs the reply matcher and tick timer, queues commands
`timescale 1ns / 1ps
`default_nettype none

module mwr_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_accept,
    input  mwr_pkg::t_in_item  i_item,
    input  wire  [7:0]         i_slave_address,
    input  wire  [15:0]        i_timeout_ticks,
    output logic               o_push,
    output mwr_pkg::t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_HUNT  = 8'b0000_0010,
        PH_FUNC  = 8'b0000_0100,
        PH_COUNT = 8'b0000_1000,
        PH_DHI   = 8'b0001_0000,
        PH_DLO   = 8'b0010_0000,
        PH_CLO   = 8'b0100_0000,
        PH_CHI   = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_data, n_data;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [15:0] r_tick, n_tick;

    logic [7:0]  w_b;
    logic [15:0] w_crc_upd;
    logic [15:0] w_crc_first;
    logic [15:0] w_tick_inc;

    assign w_b         = i_item.rx_byte;
    assign w_crc_upd   = mwr_pkg::crc_byte(r_crc, w_b);
    assign w_crc_first = mwr_pkg::crc_byte(mwr_pkg::CRC_INIT, w_b);
    assign w_tick_inc  = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_data   = r_data;
        n_crc_lo = r_crc_lo;
        n_tick   = r_tick;
        o_push   = 1'b0;
        o_cmd.op = mwr_pkg::CMD_DONE;
        o_cmd.value = r_data;
        if (i_accept) begin
            case (i_item.operation)
                mwr_pkg::OP_START: begin
                    o_push      = 1'b1;
                    o_cmd.op    = mwr_pkg::CMD_REQUEST;
                    o_cmd.value = {8'h00, i_slave_address};
                    n_tick      = '0;
                    n_phase     = PH_HUNT;
                    n_crc       = mwr_pkg::CRC_INIT;
                end
                mwr_pkg::OP_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_tick = w_tick_inc;
                        if (w_tick_inc >= i_timeout_ticks) begin
                            n_phase  = PH_IDLE;
                            o_push   = 1'b1;
                            o_cmd.op = mwr_pkg::CMD_TIMEOUT;
                        end
                    end
                end
                mwr_pkg::OP_BYTE: begin
                    case (r_phase)
                        PH_HUNT: begin
                            if (w_b == i_slave_address) begin
                                n_crc   = w_crc_first;
                                n_phase = PH_FUNC;
                            end
                        end
                        PH_FUNC: begin
                            if (w_b == mwr_pkg::FUNC_READ) begin
                                n_crc   = w_crc_upd;
                                n_phase = PH_COUNT;
                            end else begin
                                n_crc   = mwr_pkg::CRC_INIT;
                                n_phase = PH_HUNT;
                            end
                        end
                        PH_COUNT: begin
                            if (w_b == mwr_pkg::BYTE_COUNT) begin
                                n_crc   = w_crc_upd;
                                n_phase = PH_DHI;
                            end else begin
                                n_crc   = mwr_pkg::CRC_INIT;
                                n_phase = PH_HUNT;
                            end
                        end
                        PH_DHI: begin
                            n_crc   = w_crc_upd;
                            n_data  = {w_b, 8'h00};
                            n_phase = PH_DLO;
                        end
                        PH_DLO: begin
                            n_crc   = w_crc_upd;
                            n_data  = {r_data[15:8], w_b};
                            n_phase = PH_CLO;
                        end
                        PH_CLO: begin
                            n_crc_lo = w_b;
                            n_phase  = PH_CHI;
                        end
                        PH_CHI: begin
                            if (r_crc == {w_b, r_crc_lo}) begin
                                n_phase     = PH_IDLE;
                                o_push      = 1'b1;
                                o_cmd.op    = mwr_pkg::CMD_DONE;
                                o_cmd.value = r_data;
                            end else begin
                                n_crc   = mwr_pkg::CRC_INIT;
                                n_phase = PH_HUNT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_crc    <= mwr_pkg::CRC_INIT;
            r_data   <= '0;
            r_crc_lo <= '0;
            r_tick   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_data   <= n_data;
            r_crc_lo <= n_crc_lo;
            r_tick   <= n_tick;
        end
    end

endmodule

`default_nettype wire

// ----- src/mwr_back.sv -----
// Back end: expands queued commands into result transactions behind an output register
`timescale 1ns / 1ps
`default_nettype none

module mwr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mwr_pkg::t_cmd       i_cmd,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output mwr_pkg::t_out_item  o_item
);

    logic               r_busy, n_busy;
    logic [2:0]         r_idx, n_idx;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_addr, n_addr;
    logic               r_valid, n_valid;
    mwr_pkg::t_out_item r_item, n_item;

    logic               w_load;
    logic [7:0]         w_byte;

    assign w_load  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        case (r_idx)
            3'd0:    w_byte = r_addr;
            3'd1:    w_byte = mwr_pkg::FUNC_READ;
            3'd2:    w_byte = mwr_pkg::REG_HI;
            3'd3:    w_byte = mwr_pkg::REG_LO;
            3'd4:    w_byte = mwr_pkg::CNT_HI;
            3'd5:    w_byte = mwr_pkg::CNT_LO;
            3'd6:    w_byte = r_crc[7:0];
            default: w_byte = r_crc[15:8];
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_addr  = r_addr;
        n_valid = r_valid;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (w_load) begin
            if (r_busy) begin
                n_valid             = 1'b1;
                n_item.kind         = mwr_pkg::KIND_TX;
                n_item.tx_byte      = w_byte;
                n_item.wind_tenths  = '0;
                n_item.last         = (r_idx == 3'd7);
                n_idx               = r_idx + 3'd1;
                if (r_idx <= 3'd5) begin
                    n_crc = mwr_pkg::crc_byte(r_crc, w_byte);
                end
                if (r_idx == 3'd7) begin
                    n_busy = 1'b0;
                end
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_item.last = 1'b1;
                n_item.tx_byte = '0;
                n_item.wind_tenths = '0;
                case (i_cmd.op)
                    mwr_pkg::CMD_REQUEST: begin
                        n_item.kind    = mwr_pkg::KIND_TX;
                        n_item.tx_byte = i_cmd.value[7:0];
                        n_item.last    = 1'b0;
                        n_addr         = i_cmd.value[7:0];
                        n_crc          = mwr_pkg::crc_byte(mwr_pkg::CRC_INIT,
                                                           i_cmd.value[7:0]);
                        n_idx          = 3'd1;
                        n_busy         = 1'b1;
                    end
                    mwr_pkg::CMD_DONE: begin
                        n_item.kind        = mwr_pkg::KIND_DONE;
                        n_item.wind_tenths = i_cmd.value;
                    end
                    default: begin
                        n_item.kind = mwr_pkg::KIND_TIMEOUT;
                    end
                endcase
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_addr <= n_addr;
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ----- src/modbus_wind_reading_transaction.sv -----
// Top level of the Modbus RTU wind reading transaction block
// Input channel (i_in_valid / o_in_ready, i_in_data): one transaction per cycle carries a
// received byte, a time tick or a start request. It is taken whenever the command queue
// has room; the reply matcher and tick timer update in the same cycle.
// Output channel (o_out_valid / i_out_ready, o_out_data): a start yields eight request
// bytes in order, the CRC built one byte per cycle by the sequencer while not stalled;
// a good reply yields one reading, an expired timer one timeout result.
// An accepted transaction that yields a result passes through the queue and then the
// output register. Inputs sustain one per cycle while the queue has room; outputs are
// bounded by the sequencer, which sends a start's eight bytes before the next command.
// When the receiver stalls, the output register holds, the sequencer pauses, and the
// queue absorbs up to FIFO_DEPTH commands before o_in_ready drops.
// Configuration goes through the APB port: slave address at 0x0, timeout ticks at 0x4.
// Reset (synchronous, active low) sets the matcher to idle, empties the queue and
// restores slave address 1 and timeout 1000.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module modbus_wind_reading_transaction #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  mwr_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output mwr_pkg::t_out_item  o_out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0]    r_slave;
    logic [15:0]   r_timeout;
    logic          w_cfg_wr;
    logic          w_accept;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    mwr_pkg::t_cmd w_cmd_in;
    mwr_pkg::t_cmd w_cmd_out;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == mwr_pkg::REG_TIMEOUT) ? {16'h0000, r_timeout}
                                                           : {24'h000000, r_slave};
    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave   <= mwr_pkg::SLAVE_RESET;
            r_timeout <= mwr_pkg::TIMEOUT_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == mwr_pkg::REG_SLAVE) begin
                r_slave <= pwdata[7:0];
            end else begin
                r_timeout <= pwdata[15:0];
            end
        end
    end

    mwr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_item          (i_in_data),
        .i_slave_address (r_slave),
        .i_timeout_ticks (r_timeout),
        .o_push          (w_push),
        .o_cmd           (w_cmd_in)
    );

    mwr_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    mwr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

    `ASSERT_IMPL(a_push_has_room, i_clk, !i_rst_n, w_push, !w_full)
    `ASSERT_IMPL(a_pop_has_data, i_clk, !i_rst_n, w_pop, !w_empty)
    `ASSERT_NEXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !o_out_valid && w_empty)

endmodule

`default_nettype wire
